@@ hw/rtl/periodic_task_release_scheduler_top_defines.svh @@
// Assertion macros for the periodic task release scheduler.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptrs_pkg.sv @@
// Shared types, request codes and helpers for the task release scheduler.
package ptrs_pkg;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_DISPATCH = 3'd1;
  localparam logic [2:0] REQ_ADD      = 3'd2;
  localparam logic [2:0] REQ_ENABLE   = 3'd3;
  localparam logic [2:0] REQ_PERIOD   = 3'd4;
  localparam logic [2:0] REQ_RELEASE  = 3'd5;

  localparam logic [7:0] PEND_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  task_slot;
    logic [15:0] period_ticks;
    logic [15:0] first_delay;
    logic        enable_value;
    logic        rel_now;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       run_valid;
    logic [3:0] run_slot;
  } rsp_t;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] countdown;
    logic [7:0]  pending;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TICK,
    WR_DISP,
    WR_ADD,
    WR_UPD,
    WR_EN
  } wr_kind_t;

  typedef struct packed {
    logic     load_req;
    logic     rd_scan;
    logic     rd_slot;
    wr_kind_t wr;
    logic     emit;
    logic     accepted;
    logic     run_valid;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       in_table;
    logic       present;
    logic       hit;
    logic       scan_done;
    logic       out_free;
  } sts_t;

  function automatic logic [7:0] bump_pending(logic [7:0] p);
    return (p == PEND_MAX) ? p : p + 8'd1;
  endfunction

endpackage

@@ hw/rtl/ptrs_chan_if.sv @@
// Request and response channel interfaces for the task release scheduler.
interface ptrs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  task_slot;
  logic [15:0] period_ticks;
  logic [15:0] first_delay;
  logic        enable_value;
  logic        rel_now;

  modport source (
    output valid, req_type, task_slot, period_ticks, first_delay, enable_value, rel_now,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_slot, period_ticks, first_delay, enable_value, rel_now,
    output ready
  );
endinterface

interface ptrs_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       run_valid;
  logic [3:0] run_slot;

  modport source (
    output valid, accepted, run_valid, run_slot,
    input  ready
  );
  modport sink (
    input  valid, accepted, run_valid, run_slot,
    output ready
  );
endinterface

@@ hw/rtl/ptrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ptrs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/ptrs_ctrl.sv @@
// Sequencer for the task release scheduler: decodes requests and steps slot scans.
module ptrs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptrs_pkg::sts_t sts,
  output ptrs_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_DISP,
    ST_UPD,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   acc_r, acc_nxt;
  logic   hit_r, hit_nxt;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    cmd.wr    = ptrs_pkg::WR_NONE;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        hit_nxt = 1'b0;
        case (sts.req_type)
          ptrs_pkg::REQ_TICK: begin
            cmd.rd_scan = 1'b1;
            state_nxt   = ST_TICK;
          end
          ptrs_pkg::REQ_DISPATCH: begin
            cmd.rd_scan = 1'b1;
            state_nxt   = ST_DISP;
          end
          ptrs_pkg::REQ_ADD: begin
            if (sts.in_table) begin
              cmd.wr = ptrs_pkg::WR_ADD;
            end
            acc_nxt   = sts.in_table;
            state_nxt = ST_DONE;
          end
          ptrs_pkg::REQ_ENABLE: begin
            if (sts.present) begin
              cmd.wr = ptrs_pkg::WR_EN;
            end
            acc_nxt   = sts.present;
            state_nxt = ST_DONE;
          end
          ptrs_pkg::REQ_PERIOD, ptrs_pkg::REQ_RELEASE: begin
            if (sts.present) begin
              cmd.rd_slot = 1'b1;
              state_nxt   = ST_UPD;
            end else begin
              acc_nxt   = 1'b0;
              state_nxt = ST_DONE;
            end
          end
          default: begin
            acc_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_TICK: begin
        cmd.wr = ptrs_pkg::WR_TICK;
        if (sts.scan_done) begin
          acc_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      ST_DISP: begin
        if (sts.hit) begin
          cmd.wr    = ptrs_pkg::WR_DISP;
          acc_nxt   = 1'b1;
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (sts.scan_done) begin
          acc_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_scan = 1'b1;
        end
      end
      ST_UPD: begin
        cmd.wr    = ptrs_pkg::WR_UPD;
        acc_nxt   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.accepted  = acc_r;
          cmd.run_valid = hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

@@ hw/rtl/ptrs_dp.sv @@
// Datapath for the task release scheduler: slot table, scan pointer, update logic, result register.
module ptrs_dp #(
  parameter int NUM_SLOTS = 16,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ptrs_pkg::req_t in_req,
  input  ptrs_pkg::cmd_t cmd,
  output ptrs_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output ptrs_pkg::rsp_t out_rsp
);

  ptrs_pkg::req_t         req_r;
  logic [CNT_W-1:0]       ptr_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [NUM_SLOTS-1:0]   present_r;
  logic [NUM_SLOTS-1:0]   enabled_r;
  logic                   out_vld_r, out_vld_nxt;
  ptrs_pkg::rsp_t         rsp_r;

  logic [5:0]             slot_ext;
  logic [IDX_W-1:0]       req_idx;
  logic                   in_table;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [ptrs_pkg::ENTRY_W-1:0] rd_data;
  ptrs_pkg::entry_t       rd_entry;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  ptrs_pkg::entry_t       wr_data;
  logic [15:0]            cd_dec;
  logic                   tick_act;
  logic [5:0]             rd_idx_ext;

  assign slot_ext   = 6'(req_r.task_slot);
  assign req_idx    = slot_ext[IDX_W-1:0];
  assign in_table   = 7'(req_r.task_slot) < 7'(NUM_SLOTS);
  assign rd_entry   = ptrs_pkg::entry_t'(rd_data);
  assign rd_en      = cmd.rd_scan | cmd.rd_slot;
  assign rd_addr    = cmd.rd_slot ? req_idx : ptr_r[IDX_W-1:0];
  assign cd_dec     = rd_entry.countdown - 16'd1;
  assign tick_act   = present_r[rd_idx_r] && enabled_r[rd_idx_r] && (rd_entry.countdown != 16'd0);
  assign rd_idx_ext = 6'(rd_idx_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = rd_entry;
    case (cmd.wr)
      ptrs_pkg::WR_TICK: begin
        if (tick_act) begin
          wr_en = 1'b1;
          if (cd_dec == 16'd0) begin
            wr_data.pending   = ptrs_pkg::bump_pending(rd_entry.pending);
            wr_data.countdown = rd_entry.period;
          end else begin
            wr_data.countdown = cd_dec;
          end
        end
      end
      ptrs_pkg::WR_DISP: begin
        wr_en           = 1'b1;
        wr_data.pending = rd_entry.pending - 8'd1;
      end
      ptrs_pkg::WR_ADD: begin
        wr_en             = 1'b1;
        wr_addr           = req_idx;
        wr_data.period    = req_r.period_ticks;
        wr_data.countdown = req_r.first_delay;
        wr_data.pending   = 8'd0;
      end
      ptrs_pkg::WR_UPD: begin
        wr_en = 1'b1;
        if (req_r.req_type == ptrs_pkg::REQ_PERIOD) begin
          wr_data.period = req_r.period_ticks;
          if (req_r.rel_now) begin
            wr_data.pending = ptrs_pkg::bump_pending(rd_entry.pending);
          end
        end else begin
          wr_data.pending = ptrs_pkg::bump_pending(rd_entry.pending);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  ptrs_ram #(
    .WIDTH (ptrs_pkg::ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      rd_idx_r  <= '0;
      present_r <= '0;
      enabled_r <= '0;
    end else begin
      if (cmd.load_req) begin
        ptr_r <= '0;
      end else if (cmd.rd_scan) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end
      if (rd_en) begin
        rd_idx_r <= rd_addr;
      end
      if (cmd.wr == ptrs_pkg::WR_ADD) begin
        present_r[req_idx] <= 1'b1;
        enabled_r[req_idx] <= 1'b0;
      end else if (cmd.wr == ptrs_pkg::WR_EN) begin
        enabled_r[req_idx] <= req_r.enable_value;
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_r.accepted  <= cmd.accepted;
      rsp_r.run_valid <= cmd.run_valid;
      rsp_r.run_slot  <= cmd.run_valid ? rd_idx_ext[3:0] : 4'd0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = rsp_r;

  always_comb begin
    sts.req_type  = req_r.req_type;
    sts.in_table  = in_table;
    sts.present   = in_table && present_r[req_idx];
    sts.hit       = present_r[rd_idx_r] && enabled_r[rd_idx_r] && (rd_entry.pending != 8'd0);
    sts.scan_done = (ptr_r == CNT_W'(NUM_SLOTS));
    sts.out_free  = !out_vld_r || out_ready;
  end

endmodule

@@ hw/rtl/periodic_task_release_scheduler_top.sv @@
// Top level of the periodic task release scheduler (fixed-priority, run-to-completion).
// From acceptance, a tick reads every slot in order; a dispatch stops at the first pending, enabled slot.
// Add and enable write in decode; set period and release: read-modify-write of one entry.
// One transaction in flight; the next is taken once the controller is back in idle after the result
// register loads: a tick scans one slot per cycle, and a held result stalls the input.
// Reset clears present and enable flags at once; table contents need no clearing pass.
`include "periodic_task_release_scheduler_top_defines.svh"

module periodic_task_release_scheduler_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ptrs_req_if.sink          in_ch,
  ptrs_rsp_if.source        out_ch
);

  ptrs_pkg::req_t in_req;
  ptrs_pkg::cmd_t cmd;
  ptrs_pkg::sts_t sts;
  ptrs_pkg::rsp_t out_rsp;
  logic           in_ready;
  logic           out_valid;

  assign in_req.req_type     = in_ch.req_type;
  assign in_req.task_slot    = in_ch.task_slot;
  assign in_req.period_ticks = in_ch.period_ticks;
  assign in_req.first_delay  = in_ch.first_delay;
  assign in_req.enable_value = in_ch.enable_value;
  assign in_req.rel_now      = in_ch.rel_now;
  assign in_ch.ready         = in_ready;

  ptrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptrs_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_rsp)
  );

  assign out_ch.valid     = out_valid;
  assign out_ch.accepted  = out_rsp.accepted;
  assign out_ch.run_valid = out_rsp.run_valid;
  assign out_ch.run_slot  = out_rsp.run_slot;

  `PTRS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "new transaction taken while one in progress")
  `PTRS_ASSERT_NOW(a_idle_slot_zero, out_ch.valid && !out_ch.run_valid, out_ch.run_slot == 4'd0, "run_slot nonzero without a dispatched slot")
  `PTRS_ASSERT_NOW(a_run_implies_acc, out_ch.valid && out_ch.run_valid, out_ch.accepted, "dispatched slot reported without acceptance")

endmodule
